>>> rtl/jcpd_pkg.sv
`timescale 1ns / 1ps
// jcpd_pkg: shared constants for the jukes-cantor profile distance unit
// no dependencies

package jcpd_pkg;

    localparam int FIELD_W               = 16;
    localparam int DIST_W                = 18;
    localparam logic [DIST_W-1:0] DIST_MAX = 18'h3FFFF;
    localparam int LOG_FRAC              = 24;
    localparam int MANT_W                = 31;
    localparam int MUL_W                 = 32;
    localparam logic [MUL_W-1:0] LN2_Q32 = 32'hB17217F8;
    localparam int PROB_BITS_DEF         = 16;
    localparam int SITE_COUNT_LOG2_DEF   = 20;

endpackage

>>> rtl/jcpd_if.sv
`timescale 1ns / 1ps
// jcpd_site_if and jcpd_result_if: valid/ready channels of the distance unit
// depends on jcpd_pkg

interface jcpd_site_if
    import jcpd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] first_prob_a;
    logic [FIELD_W-1:0] first_prob_c;
    logic [FIELD_W-1:0] first_prob_g;
    logic [FIELD_W-1:0] first_prob_t;
    logic [FIELD_W-1:0] second_prob_a;
    logic [FIELD_W-1:0] second_prob_c;
    logic [FIELD_W-1:0] second_prob_g;
    logic [FIELD_W-1:0] second_prob_t;
    logic               last_site;

    modport source (
        output valid, first_prob_a, first_prob_c, first_prob_g, first_prob_t,
               second_prob_a, second_prob_c, second_prob_g, second_prob_t, last_site,
        input  ready
    );
    modport sink (
        input  valid, first_prob_a, first_prob_c, first_prob_g, first_prob_t,
               second_prob_a, second_prob_c, second_prob_g, second_prob_t, last_site,
        output ready
    );
endinterface

interface jcpd_result_if
    import jcpd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic              degenerate;

    modport source (output valid, distance, degenerate, input ready);
    modport sink (input valid, distance, degenerate, output ready);
endinterface

>>> rtl/jukes_cantor_profile_distance_unit.sv
`timescale 1ns / 1ps
// jukes_cantor_profile_distance_unit: site accumulator and jukes-cantor distance
// depends on jcpd_pkg, jcpd_site_if, jcpd_result_if
//
// usage
//   site: one alignment site per word, two four-base probability profiles in
//   unsigned q0.PROB_BITS plus last_site. result: one word per set of sites,
//   sent after the site marked last, distance in unsigned q2.16 and a
//   degenerate flag.
//   each site takes twelve multiply-accumulates and one norm product on the
//   shared 32x32 multiplier, then a square root that retires one root bit per
//   cycle. ready is low meanwhile.
//   a last site adds a check state and two logarithms: a normalize shift of one
//   bit per cycle and 24 squarings on the multiplier, then a subtract, one
//   scaling multiply when the distance is neither zero nor saturated, and the
//   hand-off to the output register; a degenerate set goes from the check
//   straight to the hand-off.
//   the result sits in an output register; a stalled receiver only holds the
//   unit when the next result is ready to go out.
//   reset clears both sums and empties the output register.

module jukes_cantor_profile_distance_unit
    import jcpd_pkg::*;
#(
    parameter int PROB_BITS       = PROB_BITS_DEF,
    parameter int SITE_COUNT_LOG2 = SITE_COUNT_LOG2_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    jcpd_site_if.sink     site,
    jcpd_result_if.source result
);

    localparam int P    = PROB_BITS;
    localparam int W    = P + 2 + SITE_COUNT_LOG2;
    localparam int AW   = 2 * P + 2;
    localparam int RW   = P + 2;
    localparam int XW   = 2 * RW;
    localparam int RMW  = RW + 2;
    localparam int VW   = W + 2;
    localparam int NW   = (VW > MANT_W) ? VW : MANT_W;
    localparam int CW   = $clog2(NW + 1);
    localparam int EW   = $clog2(NW);
    localparam int LW   = EW + LOG_FRAC;
    localparam int DLW  = LOG_FRAC + 3;
    localparam int D3W  = DLW + 2;
    localparam int PW   = 2 * MUL_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_NPROD = 4'd2;
    localparam logic [3:0] S_SQRT  = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_NORM  = 4'd5;
    localparam logic [3:0] S_LOG   = 4'd6;
    localparam logic [3:0] S_DIFF  = 4'd7;
    localparam logic [3:0] S_SCALE = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [P-1:0]      p_reg [4];
    logic [P-1:0]      q_reg [4];
    logic [P-1:0]      p_next [4];
    logic [P-1:0]      q_next [4];
    logic              last_reg, last_next;
    logic [AW-1:0]     acc_n1_reg, acc_n1_next;
    logic [AW-1:0]     acc_n2_reg, acc_n2_next;
    logic [AW-1:0]     acc_dot_reg, acc_dot_next;
    logic [XW-1:0]     x_reg, x_next;
    logic [RMW-1:0]    rem_reg, rem_next;
    logic [RW-1:0]     root_reg, root_next;
    logic [W-1:0]      nps_reg, nps_next;
    logic [W-1:0]      agr_reg, agr_next;
    logic [W-1:0]      same_reg, same_next;
    logic [W-1:0]      total_reg, total_next;
    logic [NW-1:0]     norm_reg, norm_next;
    logic [MANT_W-1:0] m_reg, m_next;
    logic [EW-1:0]     e_reg, e_next;
    logic [LOG_FRAC-1:0] frac_reg, frac_next;
    logic              second_reg, second_next;
    logic [LW-1:0]     la_reg, la_next;
    logic [LW-1:0]     lb_reg, lb_next;
    logic [D3W-1:0]    d3_reg, d3_next;
    logic [DIST_W-1:0] pend_dist_reg, pend_dist_next;
    logic              pend_degen_reg, pend_degen_next;
    logic              res_valid_reg, res_valid_next;
    logic [DIST_W-1:0] res_dist_reg, res_dist_next;
    logic              res_degen_reg, res_degen_next;

    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PW-1:0]     prod;
    logic [1:0]        idx, grp;
    logic [RMW-1:0]    rem_sh, trial;
    logic [W:0]        sum_wide;
    logic [W+6:0]      total_x100;
    logic [W+3:0]      same_x10, total_x3;
    logic              degen;
    logic [32:0]       sq_top;
    logic [LW-1:0]     log_val, dlog;
    logic [PW-1:0]     scaled;
    logic [PW-43:0]    dist_wide;

    assign idx = cnt_reg[1:0];
    assign grp = cnt_reg[3:2];

    // shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL:
            begin
                mul_a = MUL_W'((grp == 2'd1) ? q_reg[idx] : p_reg[idx]);
                mul_b = MUL_W'((grp == 2'd0) ? p_reg[idx] : q_reg[idx]);
            end
            S_NPROD:
            begin
                mul_a = MUL_W'(acc_n1_reg[AW-1:P]);
                mul_b = MUL_W'(acc_n2_reg[AW-1:P]);
            end
            S_LOG:
            begin
                mul_a = MUL_W'(m_reg);
                mul_b = MUL_W'(m_reg);
            end
            S_SCALE:
            begin
                mul_a = MUL_W'(d3_reg);
                mul_b = LN2_Q32;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = PW'(mul_a) * PW'(mul_b);

    // square root step, two radicand bits per cycle
    assign rem_sh = {rem_reg[RMW-3:0], x_reg[XW-1 -: 2]};
    assign trial  = {root_reg, 2'b01};

    assign total_x100 = ({total_next, 6'b0} + {1'b0, total_next, 5'b0})
                      + (W+7)'({total_next, 2'b0});
    assign same_x10   = (W+4)'({same_next, 3'b0}) + (W+4)'({same_next, 1'b0});
    assign total_x3   = (W+4)'({total_next, 1'b0}) + (W+4)'(total_next);
    assign degen      = (total_x100 <= ((W+7)'(1) << P)) || (same_x10 <= total_x3);

    assign sq_top  = prod[62:30];
    assign log_val = {e_reg, frac_next};
    assign dlog    = la_reg - lb_reg;
    assign scaled  = prod + (PW'(1) << 41);
    assign dist_wide = scaled[PW-1:42];

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        p_next          = p_reg;
        q_next          = q_reg;
        last_next       = last_reg;
        acc_n1_next     = acc_n1_reg;
        acc_n2_next     = acc_n2_reg;
        acc_dot_next    = acc_dot_reg;
        x_next          = x_reg;
        rem_next        = rem_reg;
        root_next       = root_reg;
        nps_next        = nps_reg;
        agr_next        = agr_reg;
        same_next       = same_reg;
        total_next      = total_reg;
        norm_next       = norm_reg;
        m_next          = m_reg;
        e_next          = e_reg;
        frac_next       = frac_reg;
        second_next     = second_reg;
        la_next         = la_reg;
        lb_next         = lb_reg;
        d3_next         = d3_reg;
        pend_dist_next  = pend_dist_reg;
        pend_degen_next = pend_degen_reg;
        sum_wide        = '0;
        res_valid_next  = res_valid_reg && !result.ready;
        res_dist_next   = res_dist_reg;
        res_degen_next  = res_degen_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (site.valid)
                begin
                    p_next[0]    = P'(site.first_prob_a);
                    p_next[1]    = P'(site.first_prob_c);
                    p_next[2]    = P'(site.first_prob_g);
                    p_next[3]    = P'(site.first_prob_t);
                    q_next[0]    = P'(site.second_prob_a);
                    q_next[1]    = P'(site.second_prob_c);
                    q_next[2]    = P'(site.second_prob_g);
                    q_next[3]    = P'(site.second_prob_t);
                    last_next    = site.last_site;
                    acc_n1_next  = '0;
                    acc_n2_next  = '0;
                    acc_dot_next = '0;
                    cnt_next     = '0;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                case (grp)
                    2'd0:    acc_n1_next  = acc_n1_reg + prod[AW-1:0];
                    2'd1:    acc_n2_next  = acc_n2_reg + prod[AW-1:0];
                    default: acc_dot_next = acc_dot_reg + prod[AW-1:0];
                endcase
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(11))
                begin
                    state_next = S_NPROD;
                end
            end
            S_NPROD:
            begin
                x_next    = prod[XW-1:0];
                rem_next  = '0;
                root_next = '0;
                sum_wide  = {1'b0, agr_reg} + (W+1)'(acc_dot_reg[AW-1:P]);
                agr_next  = sum_wide[W] ? '1 : sum_wide[W-1:0];
                cnt_next  = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                x_next = x_reg << 2;
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[RW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(RW - 1))
                begin
                    sum_wide   = {1'b0, nps_reg} + (W+1)'(root_next);
                    nps_next   = sum_wide[W] ? '1 : sum_wide[W-1:0];
                    state_next = last_reg ? S_CHECK : S_IDLE;
                end
            end
            S_CHECK:
            begin
                same_next   = agr_reg;
                total_next  = nps_reg;
                agr_next    = '0;
                nps_next    = '0;
                second_next = 1'b0;
                cnt_next    = '0;
                if (degen)
                begin
                    pend_dist_next  = '0;
                    pend_degen_next = 1'b1;
                    state_next      = S_EMIT;
                end
                else
                begin
                    norm_next  = NW'({nps_reg, 1'b0}) + NW'(nps_reg);
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                if (norm_reg[NW-1])
                begin
                    m_next     = norm_reg[NW-1 -: MANT_W];
                    e_next     = EW'(NW - 1) - EW'(cnt_reg);
                    frac_next  = '0;
                    cnt_next   = '0;
                    state_next = S_LOG;
                end
                else
                begin
                    norm_next = norm_reg << 1;
                    cnt_next  = cnt_reg + CW'(1);
                end
            end
            S_LOG:
            begin
                // square the mantissa, one fraction bit per squaring
                if (sq_top[31])
                begin
                    m_next    = sq_top[31:1];
                    frac_next = {frac_reg[LOG_FRAC-2:0], 1'b1};
                end
                else
                begin
                    m_next    = sq_top[30:0];
                    frac_next = {frac_reg[LOG_FRAC-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(LOG_FRAC - 1))
                begin
                    cnt_next = '0;
                    if (!second_reg)
                    begin
                        la_next     = log_val;
                        second_next = 1'b1;
                        norm_next   = NW'({same_reg, 2'b0}) - NW'(total_reg);
                        state_next  = S_NORM;
                    end
                    else
                    begin
                        lb_next    = log_val;
                        state_next = S_DIFF;
                    end
                end
            end
            S_DIFF:
            begin
                pend_degen_next = 1'b0;
                if (la_reg <= lb_reg)
                begin
                    pend_dist_next = '0;
                    state_next     = S_EMIT;
                end
                else if (dlog >= (LW'(8) << LOG_FRAC))
                begin
                    pend_dist_next = DIST_MAX;
                    state_next     = S_EMIT;
                end
                else
                begin
                    d3_next    = D3W'({dlog[DLW-1:0], 1'b0}) + D3W'(dlog[DLW-1:0]);
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                pend_dist_next = (dist_wide > (PW-42)'(DIST_MAX)) ? DIST_MAX
                                                                  : dist_wide[DIST_W-1:0];
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    res_valid_next = 1'b1;
                    res_dist_next  = pend_dist_reg;
                    res_degen_next = pend_degen_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            last_reg       <= 1'b0;
            nps_reg        <= '0;
            agr_reg        <= '0;
            second_reg     <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            last_reg       <= last_next;
            nps_reg        <= nps_next;
            agr_reg        <= agr_next;
            second_reg     <= second_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg          <= p_next;
        q_reg          <= q_next;
        acc_n1_reg     <= acc_n1_next;
        acc_n2_reg     <= acc_n2_next;
        acc_dot_reg    <= acc_dot_next;
        x_reg          <= x_next;
        rem_reg        <= rem_next;
        root_reg       <= root_next;
        same_reg       <= same_next;
        total_reg      <= total_next;
        norm_reg       <= norm_next;
        m_reg          <= m_next;
        e_reg          <= e_next;
        frac_reg       <= frac_next;
        la_reg         <= la_next;
        lb_reg         <= lb_next;
        d3_reg         <= d3_next;
        pend_dist_reg  <= pend_dist_next;
        pend_degen_reg <= pend_degen_next;
        res_dist_reg   <= res_dist_next;
        res_degen_reg  <= res_degen_next;
    end

    assign site.ready        = (state_reg == S_IDLE);
    assign result.valid      = res_valid_reg;
    assign result.distance   = res_dist_reg;
    assign result.degenerate = res_degen_reg;

endmodule

>>> tb/tb_jukes_cantor_profile_distance_unit.sv
`timescale 1ns / 1ps
// tb_jukes_cantor_profile_distance_unit: self-checking bench for the profile distance unit
// depends on jcpd_pkg, jcpd_site_if, jcpd_result_if and the unit itself
// directed site table then random site sets, scored by a bit-exact predictor or typed word

module tb_jukes_cantor_profile_distance_unit;
    import jcpd_pkg::*;

    localparam int PB       = PROB_BITS_DEF;
    localparam int SCL      = SITE_COUNT_LOG2_DEF;
    localparam logic [63:0] SUM_SAT = (64'd1 << (PB + 2 + SCL)) - 64'd1;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              degenerate;
    } dist_word_t;

    typedef struct {
        logic [FIELD_W-1:0] prob [8];
        logic               last;
        logic               typed;
        dist_word_t         typed_word;
    } site_row_t;

    logic clk;
    logic rst_n;

    jcpd_site_if   site ();
    jcpd_result_if result ();

    jukes_cantor_profile_distance_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .site   (site.sink),
        .result (result.source)
    );

    // predictor state
    logic [63:0] norm_acc;
    logic [63:0] agree_acc;
    dist_word_t  pending_dist [$];

    logic        cur_typed;
    dist_word_t  cur_typed_word;

    int errors;
    int sites_in;
    int sets_out;
    int degen_out;
    int idle_cycles;
    int hold_start;

    site_row_t directed [$];

    always #5 clk = ~clk;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > SUM_SAT) ? SUM_SAT : s;
    endfunction

    function automatic logic [63:0] log2_q24(input logic [63:0] v);
        int e;
        logic [63:0] m;
        logic [63:0] frac;
        e = 0;
        frac = 0;
        while (e < 63 && (v >> (e + 1)) != 0) e++;
        m = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
        for (int i = 0; i < LOG_FRAC; i++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31))
            begin
                frac = frac | 64'd1;
                m = m >> 1;
            end
        end
        return (64'(e) << LOG_FRAC) | frac;
    endfunction

    function automatic dist_word_t jc_distance(input logic [63:0] same, input logic [63:0] total);
        dist_word_t w;
        logic [63:0] la;
        logic [63:0] lb;
        logic [63:0] dl;
        logic [63:0] d;
        w.distance = 0;
        w.degenerate = 0;
        if (total * 100 <= (64'd1 << PB) || same * 10 <= total * 3)
        begin
            w.degenerate = 1;
            return w;
        end
        la = log2_q24(3 * total);
        lb = log2_q24(4 * same - total);
        if (la <= lb)
            d = 0;
        else
        begin
            dl = la - lb;
            if (dl >= (64'd8 << LOG_FRAC))
                d = DIST_MAX;
            else
            begin
                d = (dl * 64'(LN2_Q32) * 3 + (64'd1 << 41)) >> 42;
                if (d > DIST_MAX) d = DIST_MAX;
            end
        end
        w.distance = d[DIST_W-1:0];
        return w;
    endfunction

    // accumulate one accepted site, queue a distance on the last one
    task automatic absorb_site(input logic [FIELD_W-1:0] p [8], input logic last,
                               input logic typed, input dist_word_t typed_word);
        logic [63:0] n1;
        logic [63:0] n2;
        logic [63:0] dot;
        dist_word_t w;
        n1 = 0;
        n2 = 0;
        dot = 0;
        for (int j = 0; j < 4; j++)
        begin
            n1 = n1 + 64'(p[j]) * 64'(p[j]);
            n2 = n2 + 64'(p[j+4]) * 64'(p[j+4]);
            dot = dot + 64'(p[j]) * 64'(p[j+4]);
        end
        n1 = n1 >> PB;
        n2 = n2 >> PB;
        dot = dot >> PB;
        norm_acc = sat_sum(norm_acc, int_sqrt(n1 * n2));
        agree_acc = sat_sum(agree_acc, dot);
        if (last)
        begin
            w = jc_distance(agree_acc, norm_acc);
            if (typed) w = typed_word;
            pending_dist.insert(pending_dist.size(), w);
            norm_acc = 0;
            agree_acc = 0;
        end
    endtask

    // site monitor, result checker and watchdog, all on pre-edge values
    always @(posedge clk)
    begin
        logic [FIELD_W-1:0] p [8];
        dist_word_t want;
        int err_n;
        logic moved;
        if (rst_n)
        begin
            err_n = 0;
            moved = 0;
            if (site.valid && site.ready)
            begin
                p[0] = site.first_prob_a;  p[1] = site.first_prob_c;
                p[2] = site.first_prob_g;  p[3] = site.first_prob_t;
                p[4] = site.second_prob_a; p[5] = site.second_prob_c;
                p[6] = site.second_prob_g; p[7] = site.second_prob_t;
                absorb_site(p, site.last_site, cur_typed && site.last_site, cur_typed_word);
                sites_in <= sites_in + 1;
                moved = 1;
            end
            if (result.valid && result.ready)
            begin
                moved = 1;
                sets_out <= sets_out + 1;
                if (result.degenerate) degen_out <= degen_out + 1;
                if (pending_dist.size() == 0)
                begin
                    $display("%0t: unexpected word distance=%0d degenerate=%0b",
                             $time, result.distance, result.degenerate);
                    err_n = err_n + 1;
                end
                else
                begin
                    want = pending_dist.pop_front();
                    if (result.distance !== want.distance)
                    begin
                        $display("%0t: distance expected %0d actual %0d",
                                 $time, want.distance, result.distance);
                        err_n = err_n + 1;
                    end
                    if (result.degenerate !== want.degenerate)
                    begin
                        $display("%0t: degenerate expected %0b actual %0b",
                                 $time, want.degenerate, result.degenerate);
                        err_n = err_n + 1;
                    end
                end
            end
            errors <= errors + err_n;
            idle_cycles <= moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: watchdog, no word accepted for %0d cycles", $time, IDLE_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // receiver: random stalls plus one long hold-off while sites keep coming
    initial
    begin
        int g;
        result.ready = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (sites_in >= hold_start && hold_start > 0)
            begin
                hold_start = 0;
                result.ready <= 0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if ($urandom_range(0, 3) == 0 && sites_in < 500)
            begin
                result.ready <= 1;
                @(posedge clk);
            end
            else
            begin
                g = gap_len();
                if (g > 0)
                begin
                    result.ready <= 0;
                    repeat (g) @(posedge clk);
                end
                result.ready <= 1;
                @(posedge clk);
            end
        end
    end

    function automatic logic [FIELD_W-1:0] near_val(input logic [FIELD_W-1:0] v);
        int d;
        d = int'(v) + $urandom_range(0, 4000) - 2000;
        if (d < 0) d = 0;
        if (d > 65535) d = 65535;
        return d[FIELD_W-1:0];
    endfunction

    function automatic site_row_t random_site(input logic last);
        site_row_t s;
        int mode;
        mode = $urandom_range(0, 9);
        for (int j = 0; j < 4; j++)
        begin
            s.prob[j] = FIELD_W'($urandom_range(0, 65535));
            case (mode)
                0, 1:    s.prob[j+4] = FIELD_W'($urandom_range(0, 65535));
                2:       s.prob[j+4] = s.prob[j] ^ 16'(1 << $urandom_range(0, 15));
                default: s.prob[j+4] = near_val(s.prob[j]);
            endcase
        end
        if (mode == 9)
            for (int j = 0; j < 8; j++)
                if ($urandom_range(0, 1)) s.prob[j] = 0;
        s.last = last;
        s.typed = 0;
        s.typed_word = '0;
        return s;
    endfunction

    task automatic send_site(input site_row_t s);
        int g;
        g = gap_len();
        if (g > 0 && !(sites_in >= hold_start - 5 && hold_start > 0))
        begin
            site.valid <= 0;
            repeat (g) @(posedge clk);
        end
        site.valid <= 1;
        site.first_prob_a  <= s.prob[0];
        site.first_prob_c  <= s.prob[1];
        site.first_prob_g  <= s.prob[2];
        site.first_prob_t  <= s.prob[3];
        site.second_prob_a <= s.prob[4];
        site.second_prob_c <= s.prob[5];
        site.second_prob_g <= s.prob[6];
        site.second_prob_t <= s.prob[7];
        site.last_site     <= s.last;
        cur_typed          <= s.typed;
        cur_typed_word     <= s.typed_word;
        do @(posedge clk); while (!site.ready);
    endtask

    function automatic site_row_t row(input logic [FIELD_W-1:0] fa, fc, fg, ft,
                                      input logic [FIELD_W-1:0] sa, sc, sg, st,
                                      input logic last, input logic typed,
                                      input logic [DIST_W-1:0] d, input logic deg);
        site_row_t s;
        s.prob[0] = fa; s.prob[1] = fc; s.prob[2] = fg; s.prob[3] = ft;
        s.prob[4] = sa; s.prob[5] = sc; s.prob[6] = sg; s.prob[7] = st;
        s.last = last;
        s.typed = typed;
        s.typed_word.distance = d;
        s.typed_word.degenerate = deg;
        return s;
    endfunction

    task automatic add_row(input site_row_t s);
        directed.insert(directed.size(), s);
    endtask

    initial
    begin
        int len;
        int r;
        clk = 0;
        rst_n = 0;
        errors = 0;
        sites_in = 0;
        sets_out = 0;
        degen_out = 0;
        idle_cycles = 0;
        hold_start = 400;
        norm_acc = 0;
        agree_acc = 0;
        cur_typed = 0;
        cur_typed_word = '0;
        site.valid = 0;
        site.first_prob_a = 0;  site.first_prob_c = 0;
        site.first_prob_g = 0;  site.first_prob_t = 0;
        site.second_prob_a = 0; site.second_prob_c = 0;
        site.second_prob_g = 0; site.second_prob_t = 0;
        site.last_site = 0;

        // all-zero set, empty total: degenerate
        add_row(row(0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 1));
        // identical full-scale profiles: argument exactly one
        add_row(row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 0, 0));
        // disjoint profiles: no agreement at all
        add_row(row(16'hFFFF, 0, 0, 0, 0, 16'hFFFF, 0, 0, 1, 1, 0, 1));
        // tiny probabilities truncate to nothing
        add_row(row(1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 1));
        // one side silent
        add_row(row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 1, 1, 0, 1));
        // partial agreement, single sites
        add_row(row(16'h8000, 16'h4000, 16'h2000, 16'h2000,
                    16'h6000, 16'h4000, 16'h3000, 16'h3000, 1, 0, 0, 0));
        add_row(row(16'hC000, 16'h1000, 16'h1000, 16'h2000,
                    16'h2000, 16'hC000, 16'h1000, 16'h1000, 1, 0, 0, 0));
        add_row(row(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                    16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1, 0, 0, 0));
        // multi-site set mixing agreeing and disagreeing sites
        add_row(row(16'hFFFF, 0, 0, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0));
        add_row(row(0, 16'hFFFF, 0, 0, 0, 0, 16'hFFFF, 0, 0, 0, 0, 0));
        add_row(row(0, 0, 16'hFFFF, 0, 0, 0, 16'hFFFF, 0, 0, 0, 0, 0));
        add_row(row(0, 0, 0, 16'hFFFF, 16'hFFFF, 0, 0, 0, 1, 0, 0, 0));
        // swapped dominant bases, partial agreement
        add_row(row(16'hFFFF, 16'h5000, 0, 0, 16'h5000, 16'hFFFF, 0, 0, 1, 0, 0, 0));
        add_row(row(16'hFFFF, 16'h6000, 0, 0, 16'h6000, 16'hFFFF, 0, 0, 1, 0, 0, 0));
        // totals below and just above the small-total limit, then identical mixed profiles
        add_row(row(16'h0A00, 0, 0, 0, 16'h0A00, 0, 0, 0, 1, 0, 0, 0));
        add_row(row(16'h1A00, 0, 0, 0, 16'h1A00, 0, 0, 0, 1, 0, 0, 0));
        add_row(row(16'h1234, 16'hFEDC, 16'h0F0F, 16'hF0F0,
                    16'h1234, 16'hFEDC, 16'h0F0F, 16'hF0F0, 1, 0, 0, 0));

        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        foreach (directed[i]) send_site(directed[i]);

        // random sets, mostly short
        while (sites_in < 850)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)      len = $urandom_range(1, 4);
            else if (r < 95) len = $urandom_range(5, 12);
            else             len = $urandom_range(20, 40);
            for (int k = 0; k < len; k++)
                send_site(random_site(k == len - 1));
        end
        site.valid <= 0;

        while (pending_dist.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);

        $display("covered %0d sites in %0d sets, %0d flagged degenerate",
                 sites_in, sets_out, degen_out);
        $display("directed extremes, random profiles, gaps and a long result hold-off");
        if (errors == 0 && pending_dist.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
